>>> rtl/keyed_minmax_profile_with_bbox_core_macros.svh
// ----------------------------------------------------------------------------
// Keyed min/max profile assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef KEYED_MINMAX_PROFILE_WITH_BBOX_CORE_MACROS_SVH
`define KEYED_MINMAX_PROFILE_WITH_BBOX_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define KMMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define KMMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/kmmp_pkg.sv
// ----------------------------------------------------------------------------
// kmmp_pkg
// Types and constants shared by the keyed min/max profile block.
// ----------------------------------------------------------------------------
package kmmp_pkg;

    // 10000.0 and -10000.0 in Q16.16
    localparam logic signed [31:0] BOX_LO_RST = 32'sd655360000;
    localparam logic signed [31:0] BOX_HI_RST = -32'sd655360000;

    localparam int unsigned SLOT_W = 6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] density;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               inserted;
        logic               table_full;
        logic signed [31:0] slot_min;
        logic signed [31:0] slot_max;
        logic signed [31:0] box_lo_x;
        logic signed [31:0] box_lo_y;
        logic signed [31:0] box_lo_z;
        logic signed [31:0] box_hi_x;
        logic signed [31:0] box_hi_y;
        logic signed [31:0] box_hi_z;
    } t_out;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture input, fold into box, restart scan
        logic scan;         // issue next key read
        logic hit_commit;   // update matched slot, load result
        logic miss_commit;  // append key or flag full, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;          // registered key equals sample z
        logic done;         // all used slots read, none pending
    } t_status;

endpackage

>>> rtl/keyed_minmax_profile_with_bbox_core.sv
// ----------------------------------------------------------------------------
// keyed_minmax_profile_with_bbox_core
// Running bounding box plus a per-z-key table of min/max density.
// ----------------------------------------------------------------------------
//
//  channel   valid         ready         payload                 direction
//  input     i_in_valid    o_in_ready    i_in_data  (t_in)       sample in
//  output    o_out_valid   i_out_ready   o_out_data (t_out)      result out
//
//  Scan: a hit on slot k ends the scan at that slot; a miss reads every key
//  stored so far (none on an empty table), at most KEY_SLOTS. The key store
//  has one read port and the scan reads one stored key per cycle; the input
//  is ready again the cycle after the result loads.
//  Reset: synchronous, active low; clears the fill count, the box corners and
//  the handshake state. The stores are not cleared: only slots below the fill
//  count are ever read, so no clearing pass is needed.
//  Stalls: the result register parts the two sides; the next sample is taken
//  while a result waits, and its scan holds at the commit point until the
//  result register frees.
//
module keyed_minmax_profile_with_bbox_core #(
    parameter int unsigned KEY_SLOTS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  kmmp_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output kmmp_pkg::t_out  o_out_data
);

    // command and status between the sequencer and the datapath
    kmmp_pkg::t_cmd    cmd;
    kmmp_pkg::t_status sts;

    // sequencer: idle/scan, plus output valid
    kmmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stores, scan counter, box and result register
    kmmp_datapath #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

>>> rtl/kmmp_ctrl.sv
// ----------------------------------------------------------------------------
// kmmp_ctrl
// Sequencer for the key scan and the output register handshake.
// ----------------------------------------------------------------------------
module kmmp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  kmmp_pkg::t_status i_sts,
    output kmmp_pkg::t_cmd    o_cmd
);

    kmmp_pkg::t_state r_state, n_state;
    logic             r_out_vld, n_out_vld;
    logic             out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kmmp_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            kmmp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kmmp_pkg::ST_SCAN;
                end
            end
            kmmp_pkg::ST_SCAN: begin
                // hold the scan while the result has nowhere to go
                if (i_sts.hit) begin
                    if (out_free) begin
                        o_cmd.hit_commit = 1'b1;
                        n_state          = kmmp_pkg::ST_IDLE;
                    end
                end else if (i_sts.done) begin
                    if (out_free) begin
                        o_cmd.miss_commit = 1'b1;
                        n_state           = kmmp_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: n_state = kmmp_pkg::ST_IDLE;
        endcase
        n_out_vld = o_cmd.hit_commit || o_cmd.miss_commit || (r_out_vld && !i_out_ready);
    end

    assign o_out_valid = r_out_vld;

endmodule

>>> rtl/kmmp_datapath.sv
// ----------------------------------------------------------------------------
// kmmp_datapath
// Key/min/max stores, scan counter, bounding box and result register.
// ----------------------------------------------------------------------------
module kmmp_datapath #(
    parameter int unsigned KEY_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmmp_pkg::t_in     i_in_data,
    input  kmmp_pkg::t_cmd    i_cmd,
    output kmmp_pkg::t_status o_sts,
    output kmmp_pkg::t_out    o_out_data
);

    localparam int unsigned AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int unsigned CW = $clog2(KEY_SLOTS + 1);
    localparam int unsigned SW = (AW > kmmp_pkg::SLOT_W) ? AW : kmmp_pkg::SLOT_W;
    localparam logic [CW-1:0] USED_MAX = CW'(KEY_SLOTS);

    logic signed [31:0] mem_key [KEY_SLOTS];
    logic signed [31:0] mem_min [KEY_SLOTS];
    logic signed [31:0] mem_max [KEY_SLOTS];

    kmmp_pkg::t_in      r_in;
    kmmp_pkg::t_out     r_out;
    logic signed [31:0] r_lo_x, r_lo_y, r_lo_z, r_hi_x, r_hi_y, r_hi_z;
    logic [CW-1:0]      r_used, r_scan;
    logic [AW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic signed [31:0] r_key_rd, r_min_rd, r_max_rd;

    logic               rd_en, room, wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] hit_min, hit_max, wr_min, wr_max;
    logic [SW-1:0]      slot_ext;

    assign rd_en   = i_cmd.scan && (r_scan < r_used);
    assign room    = r_used < USED_MAX;
    assign hit_min = (r_min_rd > r_in.density) ? r_in.density : r_min_rd;
    assign hit_max = (r_max_rd < r_in.density) ? r_in.density : r_max_rd;
    assign wr_en   = i_cmd.hit_commit || (i_cmd.miss_commit && room);
    assign wr_addr = i_cmd.hit_commit ? r_rd_idx : r_used[AW-1:0];
    assign wr_min  = i_cmd.hit_commit ? hit_min : r_in.density;
    assign wr_max  = i_cmd.hit_commit ? hit_max : r_in.density;
    assign slot_ext = SW'(wr_addr);

    assign o_sts.hit  = r_rd_vld && (r_key_rd == r_in.pos_z);
    assign o_sts.done = !r_rd_vld && (r_scan == r_used);

    // store arrays: one read and one write port each
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_key_rd <= mem_key[r_scan[AW-1:0]];
            r_min_rd <= mem_min[r_scan[AW-1:0]];
            r_max_rd <= mem_max[r_scan[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr] <= r_in.pos_z;
            mem_min[wr_addr] <= wr_min;
            mem_max[wr_addr] <= wr_max;
        end
    end

    // scan control and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_scan   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan   <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= rd_en;
                if (rd_en) begin
                    r_scan <= r_scan + CW'(1);
                end
            end
            if (i_cmd.miss_commit && room) begin
                r_used <= r_used + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx <= r_scan[AW-1:0];
        end
    end

    // bounding box: fold the sample in at capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_x <= kmmp_pkg::BOX_LO_RST;
            r_lo_y <= kmmp_pkg::BOX_LO_RST;
            r_lo_z <= kmmp_pkg::BOX_LO_RST;
            r_hi_x <= kmmp_pkg::BOX_HI_RST;
            r_hi_y <= kmmp_pkg::BOX_HI_RST;
            r_hi_z <= kmmp_pkg::BOX_HI_RST;
        end else if (i_cmd.load) begin
            if (i_in_data.pos_x < r_lo_x) r_lo_x <= i_in_data.pos_x;
            if (i_in_data.pos_y < r_lo_y) r_lo_y <= i_in_data.pos_y;
            if (i_in_data.pos_z < r_lo_z) r_lo_z <= i_in_data.pos_z;
            if (i_in_data.pos_x > r_hi_x) r_hi_x <= i_in_data.pos_x;
            if (i_in_data.pos_y > r_hi_y) r_hi_y <= i_in_data.pos_y;
            if (i_in_data.pos_z > r_hi_z) r_hi_z <= i_in_data.pos_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_commit || i_cmd.miss_commit) begin
            r_out.box_lo_x <= r_lo_x;
            r_out.box_lo_y <= r_lo_y;
            r_out.box_lo_z <= r_lo_z;
            r_out.box_hi_x <= r_hi_x;
            r_out.box_hi_y <= r_hi_y;
            r_out.box_hi_z <= r_hi_z;
            if (wr_en) begin
                r_out.slot       <= slot_ext[kmmp_pkg::SLOT_W-1:0];
                r_out.inserted   <= i_cmd.miss_commit;
                r_out.table_full <= 1'b0;
                r_out.slot_min   <= wr_min;
                r_out.slot_max   <= wr_max;
            end else begin
                r_out.slot       <= '0;
                r_out.inserted   <= 1'b0;
                r_out.table_full <= 1'b1;
                r_out.slot_min   <= '0;
                r_out.slot_max   <= '0;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

>>> rtl/kmmp_checker.sv
// ----------------------------------------------------------------------------
// kmmp_checker
// Port-level checks on the keyed min/max profile block.
// ----------------------------------------------------------------------------
`include "keyed_minmax_profile_with_bbox_core_macros.svh"

module kmmp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input kmmp_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input kmmp_pkg::t_out o_out_data
);

    kmmp_pkg::t_out     res;
    logic signed [31:0] lo_x, hi_x, lo_z, hi_z;
    logic               out_stall, in_stall, full_clr, ins_flat, box_ok;

    assign res  = o_out_data;
    assign lo_x = res.box_lo_x;
    assign hi_x = res.box_hi_x;
    assign lo_z = res.box_lo_z;
    assign hi_z = res.box_hi_z;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_stall  = i_in_valid && !o_in_ready;
    assign full_clr  = !res.inserted && res.slot == '0
                       && res.slot_min == '0 && res.slot_max == '0;
    assign ins_flat  = res.slot_min == res.slot_max;
    assign box_ok    = lo_x <= hi_x && lo_z <= hi_z && res.slot_min <= res.slot_max;

    // a result waiting for transfer stays valid and unchanged
    `KMMP_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(res), "stalled result moved")

    // a waiting sample stays valid and unchanged
    `KMMP_ASSERT_NEXT(a_in_hold, in_stall, i_in_valid && $stable(i_in_data), "sample moved")

    // a dropped key reports an empty slot
    `KMMP_ASSERT_NOW(a_full_empty, o_out_valid && res.table_full, full_clr, "full not cleared")

    // a new key starts with min equal to max
    `KMMP_ASSERT_NOW(a_ins_flat, o_out_valid && res.inserted, ins_flat, "new key min != max")

    // every reported box already holds at least one sample
    `KMMP_ASSERT_NOW(a_box_order, o_out_valid, box_ok, "box or slot range inverted")

endmodule

bind keyed_minmax_profile_with_bbox_core kmmp_checker u_kmmp_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: keyed min/max profile with bounding box
// Drives samples into keyed_minmax_profile_with_bbox_core, works out each
// result with an in-bench profile of the key table and box, and compares
// every result transfer field by field. A short stimulus table covers the
// box corners, field extremes, key hits and near-miss keys. Random traffic
// follows: mostly repeated keys with fresh keys mixed in until the table
// overflows. The random part runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

    typedef kmmp_pkg::t_in  t_in;
    typedef kmmp_pkg::t_out t_out;

    localparam int KEY_SLOTS   = 64;
    localparam int SLOT_W      = kmmp_pkg::SLOT_W;
    localparam int RAND_ITEMS  = 250;   // per idling phase, four phases
    localparam int IDLE_LIMIT  = 4000;  // cycles without any transfer
    localparam int DRAIN_TAIL  = KEY_SLOTS + 40;

    localparam logic signed [31:0] BOX_LO_RST = kmmp_pkg::BOX_LO_RST;
    localparam logic signed [31:0] BOX_HI_RST = kmmp_pkg::BOX_HI_RST;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

    // ------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------
    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    t_in   in_data   = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    t_out  out_data;

    always #4 clk = ~clk;

    keyed_minmax_profile_with_bbox_core #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Profile state kept by the bench: key table plus box corners
    // ------------------------------------------------------------------
    logic signed [31:0] key_tab [KEY_SLOTS];
    logic signed [31:0] min_tab [KEY_SLOTS];
    logic signed [31:0] max_tab [KEY_SLOTS];
    int                 key_fill = 0;
    logic signed [31:0] box_lo [3] = '{BOX_LO_RST, BOX_LO_RST, BOX_LO_RST};
    logic signed [31:0] box_hi [3] = '{BOX_HI_RST, BOX_HI_RST, BOX_HI_RST};

    t_out               profile_q [$];   // results owed by the DUT, oldest first
    logic signed [31:0] known_z [$];     // z keys sent so far, for reuse
    int                 err_cnt   = 0;
    int                 gap_pct   = 0;   // sender idle chance, percent
    int                 stall_pct = 0;   // receiver stall chance, percent

    typedef struct {
        t_in  smp;
        bit   typed;    // want holds a hand-written result
        t_out want;
    } t_probe;

    t_probe probe_tab [$];

    // Append one row to the stimulus table.
    function automatic void add_probe(input t_in smp, input bit typed, input t_out want);
        t_probe p;
        p.smp     = smp;
        p.typed   = typed;
        p.want    = want;
        probe_tab = {probe_tab, p};
    endfunction

    // Fold one sample into the profile and return the result it must produce.
    function automatic t_out fold_sample(input t_in s);
        t_out               r;
        logic signed [31:0] crd [3];
        int                 at;
        crd[0] = s.pos_x;
        crd[1] = s.pos_y;
        crd[2] = s.pos_z;
        r  = '0;
        at = -1;
        // Box corners move only when a coordinate lies strictly beyond them.
        for (int a = 0; a < 3; a++) begin
            if (crd[a] < box_lo[a]) box_lo[a] = crd[a];
            if (crd[a] > box_hi[a]) box_hi[a] = crd[a];
        end
        for (int k = 0; k < key_fill; k++) begin
            if (at < 0 && key_tab[k] == s.pos_z) at = k;
        end
        if (at >= 0) begin
            if (s.density < min_tab[at]) min_tab[at] = s.density;
            if (s.density > max_tab[at]) max_tab[at] = s.density;
        end else if (key_fill < KEY_SLOTS) begin
            at          = key_fill;
            key_tab[at] = s.pos_z;
            min_tab[at] = s.density;
            max_tab[at] = s.density;
            key_fill++;
            r.inserted  = 1'b1;
        end else begin
            // Table overflow: drop the key, report slot 0 with zero min/max.
            r.table_full = 1'b1;
        end
        if (!r.table_full) begin
            r.slot     = at[SLOT_W-1:0];
            r.slot_min = min_tab[at];
            r.slot_max = max_tab[at];
        end
        r.box_lo_x = box_lo[0];
        r.box_lo_y = box_lo[1];
        r.box_lo_z = box_lo[2];
        r.box_hi_x = box_hi[0];
        r.box_hi_y = box_hi[1];
        r.box_hi_z = box_hi[2];
        return r;
    endfunction

    function automatic t_in mk_sample(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] d);
        t_in s;
        s.pos_x   = x;
        s.pos_y   = y;
        s.pos_z   = z;
        s.density = d;
        return s;
    endfunction

    function automatic t_out mk_result(
        input int slot, input int ins, input int full,
        input logic [31:0] mn, input logic [31:0] mx,
        input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
        input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
        t_out r;
        r.slot       = slot[SLOT_W-1:0];
        r.inserted   = ins[0];
        r.table_full = full[0];
        r.slot_min   = mn;
        r.slot_max   = mx;
        r.box_lo_x   = lx;
        r.box_lo_y   = ly;
        r.box_lo_z   = lz;
        r.box_hi_x   = hx;
        r.box_hi_y   = hy;
        r.box_hi_z   = hz;
        return r;
    endfunction

    // Random sample: mostly keys seen before, with fresh, near-miss and
    // corner keys mixed in so the table fills and then overflows.
    function automatic t_in draw_sample();
        t_in         s;
        int unsigned pick;
        s.pos_x   = $urandom;
        s.pos_y   = $urandom;
        s.density = $urandom;
        case ($urandom_range(4))
            0:       s.density = Q_MIN;
            1:       s.density = Q_MAX;
            default: ;
        endcase
        pick = $urandom_range(99);
        if (pick < 55 && known_z.size() != 0) begin
            s.pos_z = known_z[$urandom_range(known_z.size() - 1)];
        end else if (pick < 65 && known_z.size() != 0) begin
            // flip one bit of a stored key: must not match it
            s.pos_z = known_z[$urandom_range(known_z.size() - 1)]
                      ^ (32'h1 << $urandom_range(31));
        end else if (pick < 75) begin
            case ($urandom_range(5))
                0:       s.pos_z = Q_MIN;
                1:       s.pos_z = Q_MAX;
                2:       s.pos_z = '0;
                3:       s.pos_z = '1;
                4:       s.pos_z = BOX_LO_RST;
                default: s.pos_z = BOX_HI_RST;
            endcase
        end else begin
            s.pos_z = $urandom;
        end
        return s;
    endfunction

    // Present one sample, hold it until transfer, then record what it owes.
    task automatic send_sample(input t_in s, input bit typed, input t_out want);
        t_out pred;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        pred = fold_sample(s);
        if (pred.inserted || pred.table_full) known_z = {known_z, s.pos_z};
        profile_q = {profile_q, (typed ? want : pred)};
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %08h, got %08h", name, want, got);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, and a check of every result transfer
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin : result_check
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (profile_q.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", out_data);
                err_cnt++;
            end else begin
                want = profile_q.pop_front();
                check_field("slot",       32'(want.slot),       32'(out_data.slot));
                check_field("inserted",   32'(want.inserted),   32'(out_data.inserted));
                check_field("table_full", 32'(want.table_full), 32'(out_data.table_full));
                check_field("slot_min",   want.slot_min,   out_data.slot_min);
                check_field("slot_max",   want.slot_max,   out_data.slot_max);
                check_field("box_lo_x",   want.box_lo_x,   out_data.box_lo_x);
                check_field("box_lo_y",   want.box_lo_y,   out_data.box_lo_y);
                check_field("box_lo_z",   want.box_lo_z,   out_data.box_lo_z);
                check_field("box_hi_x",   want.box_hi_x,   out_data.box_hi_x);
                check_field("box_hi_y",   want.box_hi_y,   out_data.box_hi_y);
                check_field("box_hi_z",   want.box_hi_z,   out_data.box_hi_z);
            end
        end
    end

    // Watchdog: a run of cycles with no transfer on either side ends the run.
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("keyed_minmax_profile_with_bbox_core verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int gap_by_phase   [4] = '{0, 52, 0, 33};
    int stall_by_phase [4] = '{0, 0, 52, 33};

    initial begin
        // First sample sits exactly on the +10000 low corner in x and on the
        // -10000 high corner in y: equal is not beyond, so those hold.
        add_probe(mk_sample(BOX_LO_RST, BOX_HI_RST, 32'h0, 32'h0), 1'b1,
            mk_result(0, 1, 0, 32'h0, 32'h0,
                      BOX_LO_RST, BOX_HI_RST, 32'h0, BOX_LO_RST, BOX_HI_RST, 32'h0));
        // One LSB inside each corner: only the opposite corner moves.
        add_probe(mk_sample(BOX_LO_RST - 1, BOX_HI_RST + 1, 32'h0, 32'h1), 1'b1,
            mk_result(0, 0, 0, 32'h0, 32'h1,
                      BOX_LO_RST - 1, BOX_HI_RST, 32'h0,
                      BOX_LO_RST, BOX_HI_RST + 1, 32'h0));
        // Field extremes, both polarities.
        add_probe(mk_sample(Q_MAX, Q_MIN, Q_MIN, Q_MAX), 1'b1,
            mk_result(1, 1, 0, Q_MAX, Q_MAX,
                      BOX_LO_RST - 1, Q_MIN, Q_MIN, Q_MAX, BOX_HI_RST + 1, 32'h0));
        add_probe(mk_sample(Q_MIN, Q_MAX, Q_MAX, Q_MIN), 1'b1,
            mk_result(2, 1, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        // Hits on stored keys widen min and max; box is pinned at the extremes.
        add_probe(mk_sample(32'h0, 32'h0, Q_MIN, Q_MIN), 1'b1,
            mk_result(1, 0, 0, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        add_probe(mk_sample(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b1,
            mk_result(0, 0, 0, 32'hFFFF_FFFF, 32'h1,
                      Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        add_probe(mk_sample(32'h0, 32'h0, Q_MAX, Q_MAX), 1'b1,
            mk_result(2, 0, 0, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        // Near-miss keys and further hits, checked against the profile.
        add_probe(mk_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h1, 32'h1234_5678),
                  1'b0, '0);
        add_probe(mk_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0),
                  1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, 32'h8000_0001, 32'h8000_0001), 1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, 32'h7FFF_FFFE, 32'h7FFF_FFFE), 1'b0, '0);
        add_probe(mk_sample(32'h1, 32'h1, 32'h1, Q_MIN), 1'b0, '0);
        add_probe(mk_sample(32'h1, 32'h1, 32'h1, Q_MAX), 1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000), 1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_8000), 1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, BOX_LO_RST, BOX_LO_RST), 1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, BOX_HI_RST, BOX_HI_RST), 1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
        add_probe(mk_sample(32'hFFFF_FFFF, 32'h0, 32'h5555_5555, 32'hAAAA_AAAA),
                  1'b0, '0);
        add_probe(mk_sample(32'h0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555),
                  1'b0, '0);
        add_probe(mk_sample(32'h0, 32'h0, 32'h5555_5555, 32'h5555_5555), 1'b0, '0);

        // Hold reset, then release it for good.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stimulus table, no idling on either side.
        foreach (probe_tab[n]) begin
            send_sample(probe_tab[n].smp, probe_tab[n].typed, probe_tab[n].want);
        end

        // Random traffic under each idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            gap_pct   = gap_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            if (ph == 2) begin
                // Hold the sender until every outstanding result has arrived.
                in_valid <= 1'b0;
                do @(posedge clk); while (profile_q.size() != 0);
            end
            for (int n = 0; n < RAND_ITEMS; n++) begin
                send_sample(draw_sample(), 1'b0, '0);
            end
        end

        // Drain: wait for the last results, then give the scan time to show
        // any stray transfer.
        in_valid <= 1'b0;
        do @(posedge clk); while (profile_q.size() != 0);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (err_cnt == 0) begin
            $display("keyed_minmax_profile_with_bbox_core verification clean");
        end else begin
            $display("keyed_minmax_profile_with_bbox_core verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/kmmp_pkg.sv
rtl/kmmp_ctrl.sv
rtl/kmmp_datapath.sv
rtl/keyed_minmax_profile_with_bbox_core.sv
rtl/kmmp_checker.sv
tb/tb_top.sv
